### sv/spq_pkg.sv
// Shared constants, codes and types of the scan priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int DEPTH      = 16;
  localparam int PRIO_WIDTH = 8;
  localparam int DATA_W     = 32;
  localparam int PRIO_IN_W  = 8;
  localparam int FILL_W     = 5;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W    = PRIO_WIDTH + DATA_W;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    status_t           status;
    logic [FILL_W-1:0] fill;
  } result_t;

endpackage

`default_nettype wire

### sv/spq_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int WIDTH   = 8,
  parameter int DEPTH_P = 16,
  localparam int AW     = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/spq_ctrl.sv
// Sequencer: append on enqueue, scan then compact the entry RAM on dequeue.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 req_type,
  input  wire logic [DATA_W-1:0]    data_in,
  input  wire logic [PRIO_IN_W-1:0] prio_in,
  output result_t                   res,
  input  wire logic                 res_ready,
  output logic                      ram_we,
  output logic      [IDX_W-1:0]     ram_waddr,
  output logic      [ENTRY_W-1:0]   ram_wdata,
  output logic                      ram_re,
  output logic      [IDX_W-1:0]     ram_raddr,
  input  wire logic [ENTRY_W-1:0]   ram_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      iss;        // next position to read
  logic                  pend;       // read data arrives this cycle
  logic [IDX_W-1:0]      pend_pos;
  logic [IDX_W-1:0]      best_idx;
  logic [PRIO_WIDTH-1:0] best_prio;
  logic [DATA_W-1:0]     best_data;
  logic [DATA_W-1:0]     res_data;
  status_t               res_status;

  logic                  accept;
  logic                  rd_issue;
  logic [PRIO_WIDTH-1:0] rd_prio;
  logic [DATA_W-1:0]     rd_data;
  logic                  take;
  logic                  scan_done;
  logic                  shift_done;
  logic [IDX_W-1:0]      best_idx_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign rd_issue  = ((state == S_SCAN) || (state == S_SHIFT)) && (iss < count);
  assign ram_re    = rd_issue;
  assign ram_raddr = iss[IDX_W-1:0];
  assign rd_prio   = ram_rdata[ENTRY_W-1:DATA_W];
  assign rd_data   = ram_rdata[DATA_W-1:0];

  // Strict compare keeps the oldest entry on equal priority.
  assign take = (state == S_SCAN) && pend && ((pend_pos == '0) || (rd_prio > best_prio));
  assign best_idx_next = take ? pend_pos : best_idx;
  assign scan_done  = (state == S_SCAN) && pend &&
                      (CNT_W'(pend_pos) == (count - CNT_W'(1)));
  assign shift_done = (state == S_SHIFT) && !rd_issue && !pend;

  // Append writes at the tail; compaction writes one place below the read.
  // Compaction reads position p+1 while writing p-1, so no overlap arises.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = {prio_in[PRIO_WIDTH-1:0], data_in};
    if (accept && (req_t'(req_type) == REQ_ENQ) && (count < CNT_W'(DEPTH))) begin
      ram_we = 1'b1;
    end else if ((state == S_SHIFT) && pend) begin
      ram_we    = 1'b1;
      ram_waddr = pend_pos - IDX_W'(1);
      ram_wdata = ram_rdata;
    end
  end

  assign res.valid  = (state == S_RESP);
  assign res.data   = res_data;
  assign res.status = res_status;
  assign res.fill   = FILL_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_data <= '0;
            if (req_t'(req_type) == REQ_DEQ) begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_RESP;
              end else begin
                iss   <= '0;
                pend  <= 1'b0;
                state <= S_SCAN;
              end
            end else if (count >= CNT_W'(DEPTH)) begin
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else begin
              count      <= count + CNT_W'(1);
              res_status <= ST_ENQ;
              state      <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          pend     <= rd_issue;
          pend_pos <= iss[IDX_W-1:0];
          if (rd_issue) begin
            iss <= iss + CNT_W'(1);
          end
          if (take) begin
            best_prio <= rd_prio;
            best_idx  <= pend_pos;
            best_data <= rd_data;
          end
          if (scan_done) begin
            pend  <= 1'b0;
            iss   <= CNT_W'(best_idx_next) + CNT_W'(1);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          pend     <= rd_issue;
          pend_pos <= iss[IDX_W-1:0];
          if (rd_issue) begin
            iss <= iss + CNT_W'(1);
          end
          if (shift_done) begin
            count      <= count - CNT_W'(1);
            res_data   <= best_data;
            res_status <= ST_DEQ;
            state      <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_no_same_addr: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write hit the same entry");

  a_deq_drops_one: assert property (@(posedge clk) disable iff (rst)
    shift_done |=> (count == $past(count) - CNT_W'(1)))
    else $error("dequeue did not remove exactly one entry");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    pend |-> (CNT_W'(pend_pos) < count))
    else $error("read beyond held entries");
`endif

endmodule

`default_nettype wire

### sv/scan_priority_queue_unit.sv
// Top level of the scan priority queue: entry RAM, sequencer, output register.
// Enqueue, full enqueue, empty dequeue: the response state is registered, then the output register raises m_tvalid.
// Dequeue of n held entries, winner at b: a scan of all n, then compaction of the n - b - 1 above b;
//   both passes share the single RAM read port. A new input is taken only once the sequencer is idle.
// m_tready held low while the output register holds a result keeps the sequencer in its response state,
// so the input waits too. rst (synchronous, active high) empties the queue; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module scan_priority_queue_unit
  import spq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [31:0] data_in, [39:32] prio_in
  input  wire logic        s_tuser,   // [0] req_type
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [31:0] data_out, [36:32] fill_level, [39:37] zero
  output logic      [1:0]  m_tuser    // [1:0] status
);

  result_t              res;
  logic                 res_ready;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [DATA_W-1:0]    out_data;
  logic [FILL_W-1:0]    out_fill;
  status_t              out_status;

  // Entry store: priority in the upper bits, data word below.
  spq_ram #(
    .WIDTH   (ENTRY_W),
    .DEPTH_P (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req_type  (s_tuser),
    .data_in   (s_tdata[DATA_W-1:0]),
    .prio_in   (s_tdata[DATA_W +: PRIO_IN_W]),
    .res       (res),
    .res_ready (res_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Output register: holds a finished transaction while the sequencer
  // goes back to take the next input.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
      if (res.valid) begin
        out_data   <= res.data;
        out_status <= res.status;
        out_fill   <= res.fill;
      end
    end
  end

  assign m_tdata = {3'b000, out_fill, out_data};
  assign m_tuser = out_status;

endmodule

`default_nettype wire
